// ----- rtl/core/hdtm_pkg.sv -----
`timescale 1ns / 1ps
// hdtm_pkg: shared types and constants for the header dynamic table manager
package hdtm_pkg;

   // fixed field widths
   localparam int LEN_W     = 16;
   localparam int TAG_W     = 32;
   localparam int OCT_W     = 32;
   localparam int IDX_W     = 16;
   localparam int CNT_OUT_W = 10;
   localparam int COST_W    = 18;

   // parameter defaults
   localparam int DEF_RING_DEPTH     = 512;
   localparam int DEF_ENTRY_OVERHEAD = 32;
   localparam int DEF_STATIC_ENTRIES = 61;

   // table limit after reset
   localparam logic [OCT_W-1:0] LIMIT_RESET = 32'd4096;

   // request codes
   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_RESIZE = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2,
      STATUS_CLEARED = 2'd3
   } status_type;

   // controller sequencing states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EVICT,
      ST_EVICT_WAIT,
      ST_COMMIT,
      ST_LOOK_WAIT,
      ST_DONE
   } state_type;

   // one stored table entry
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] name_len;
      logic [LEN_W-1:0] value_len;
   } entry_type;

   // finished response handed to the output stage
   typedef struct packed {
      status_type           status;
      entry_type            found;
      logic [CNT_OUT_W-1:0] evicted_count;
      logic [CNT_OUT_W-1:0] entry_count;
      logic [OCT_W-1:0]     octet_total;
   } result_type;

endpackage

// ----- rtl/core/hdtm_ring_mem.sv -----
`timescale 1ns / 1ps
// hdtm_ring_mem: entry ring storage, one write and one registered read port
module hdtm_ring_mem
   import hdtm_pkg::*;
#(
   parameter int DEPTH = DEF_RING_DEPTH
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/hdtm_ctrl.sv -----
`timescale 1ns / 1ps
// hdtm_ctrl: request sequencer, ring pointers, size accounting and eviction walk
module hdtm_ctrl
   import hdtm_pkg::*;
#(
   parameter int RING_DEPTH     = DEF_RING_DEPTH,
   parameter int ENTRY_OVERHEAD = DEF_ENTRY_OVERHEAD,
   parameter int STATIC_ENTRIES = DEF_STATIC_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [LEN_W-1:0]              req_name_len,
   input  logic [LEN_W-1:0]              req_value_len,
   input  logic [TAG_W-1:0]              req_entry_tag,
   input  logic [IDX_W-1:0]              req_lookup_index,
   input  logic [OCT_W-1:0]              req_new_limit,
   // finished result
   output logic                          done_valid,
   input  logic                          done_take,
   output result_type                    done_result,
   // ring memory
   output logic                          mem_rd_en,
   output logic [$clog2(RING_DEPTH)-1:0] mem_rd_addr,
   input  entry_type                     mem_rd_data,
   output logic                          mem_wr_en,
   output logic [$clog2(RING_DEPTH)-1:0] mem_wr_addr,
   output entry_type                     mem_wr_data
);

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = SLOT_W + 1;
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RING_DEPTH);
   localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(RING_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
   localparam logic [IDX_W-1:0]  STATIC_IDX = IDX_W'(STATIC_ENTRIES);
   localparam logic [IDX_W-1:0]  FIRST_DYN  = IDX_W'(STATIC_ENTRIES + 1);
   localparam logic [COST_W-1:0] OVERHEAD   = COST_W'(ENTRY_OVERHEAD);

   // reduce a sum below twice the depth to a slot number
   function automatic logic [SLOT_W-1:0] ring_wrap(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] red;
      red = (sum >= DEPTH_SUM) ? sum - DEPTH_SUM : sum;
      return red[SLOT_W-1:0];
   endfunction

   state_type           state_ff, state_in;
   req_code_type        op_ff, op_in;
   logic [LEN_W-1:0]    nlen_ff, nlen_in;
   logic [LEN_W-1:0]    vlen_ff, vlen_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [IDX_W-1:0]    vidx_ff, vidx_in;
   logic [OCT_W-1:0]    lim_ff, lim_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [OCT_W-1:0]    total_ff, total_in;
   logic [OCT_W-1:0]    limit_ff, limit_in;
   logic [OCT_W-1:0]    target_ff, target_in;
   logic [CNT_W-1:0]    evicted_ff, evicted_in;
   logic                clear_ff, clear_in;
   status_type          status_ff, status_in;
   entry_type           found_ff, found_in;

   logic [COST_W-1:0]   add_cost;
   logic [COST_W-1:0]   tail_cost;
   logic [OCT_W-1:0]    tail_cost_ext;
   logic [IDX_W-1:0]    dyn_idx;
   logic [SLOT_W-1:0]   new_head;
   logic [SLOT_W-1:0]   tail_slot;
   logic [SLOT_W-1:0]   look_slot;

   // entry costs and ring positions
   assign add_cost      = COST_W'(nlen_ff) + COST_W'(vlen_ff) + OVERHEAD;
   assign tail_cost     = COST_W'(mem_rd_data.name_len) + COST_W'(mem_rd_data.value_len)
                          + OVERHEAD;
   assign tail_cost_ext = OCT_W'(tail_cost);
   assign dyn_idx       = vidx_ff - FIRST_DYN;
   assign new_head      = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign tail_slot     = ring_wrap(SUM_W'(head_ff) + SUM_W'(held_ff) - 1'b1);
   assign look_slot     = ring_wrap(SUM_W'(head_ff) + SUM_W'(dyn_idx[SLOT_W-1:0]));

   assign req_stall = (state_ff != ST_IDLE);

   // state and table registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         held_ff  <= '0;
         total_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         held_ff  <= held_in;
         total_ff <= total_in;
         limit_ff <= limit_in;
      end
   end

   // request payload and working registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      nlen_ff    <= nlen_in;
      vlen_ff    <= vlen_in;
      tag_ff     <= tag_in;
      vidx_ff    <= vidx_in;
      lim_ff     <= lim_in;
      target_ff  <= target_in;
      evicted_ff <= evicted_in;
      clear_ff   <= clear_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
   end

   // next state and memory access
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      nlen_in     = nlen_ff;
      vlen_in     = vlen_ff;
      tag_in      = tag_ff;
      vidx_in     = vidx_ff;
      lim_in      = lim_ff;
      head_in     = head_ff;
      held_in     = held_ff;
      total_in    = total_ff;
      limit_in    = limit_ff;
      target_in   = target_ff;
      evicted_in  = evicted_ff;
      clear_in    = clear_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = tail_slot;
      mem_wr_en   = 1'b0;
      mem_wr_addr = new_head;
      mem_wr_data = '{tag: tag_ff, name_len: nlen_ff, value_len: vlen_ff};
      done_valid  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_code_type'(req_type);
               nlen_in    = req_name_len;
               vlen_in    = req_value_len;
               tag_in     = req_entry_tag;
               vidx_in    = req_lookup_index;
               lim_in     = req_new_limit;
               evicted_in = '0;
               clear_in   = 1'b0;
               status_in  = STATUS_OK;
               found_in   = '0;
               state_in   = ST_DECIDE;
            end
         end

         // classify the request against the current table
         ST_DECIDE: begin
            case (op_ff)
               REQ_ADD: begin
                  if (held_ff == FULL_CNT) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else if (OCT_W'(add_cost) > limit_ff) begin
                     clear_in  = 1'b1;
                     target_in = '0;
                     status_in = STATUS_CLEARED;
                     state_in  = ST_EVICT;
                  end else begin
                     target_in = limit_ff - OCT_W'(add_cost);
                     state_in  = ST_EVICT;
                  end
               end
               REQ_LOOKUP: begin
                  if (vidx_ff <= STATIC_IDX) begin
                     status_in = STATUS_MISSING;
                     state_in  = ST_DONE;
                  end else if (dyn_idx >= IDX_W'(held_ff)) begin
                     status_in = STATUS_MISSING;
                     state_in  = ST_DONE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = look_slot;
                     state_in    = ST_LOOK_WAIT;
                  end
               end
               REQ_RESIZE: begin
                  target_in = lim_ff;
                  state_in  = (lim_ff < total_ff) ? ST_EVICT : ST_COMMIT;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         // fetch the oldest entry while the table is over target
         ST_EVICT: begin
            if ((total_ff > target_ff) && (held_ff != '0)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = tail_slot;
               state_in    = ST_EVICT_WAIT;
            end else begin
               if (held_ff == '0) begin
                  total_in = '0;
               end
               state_in = ST_COMMIT;
            end
         end

         // drop the fetched oldest entry from the accounting
         ST_EVICT_WAIT: begin
            held_in    = held_ff - 1'b1;
            total_in   = (total_ff >= tail_cost_ext) ? total_ff - tail_cost_ext : '0;
            evicted_in = evicted_ff + 1'b1;
            state_in   = ST_EVICT;
         end

         // prepend the new entry or adopt the new limit
         ST_COMMIT: begin
            case (op_ff)
               REQ_ADD: begin
                  if (!clear_ff) begin
                     mem_wr_en = 1'b1;
                     head_in   = new_head;
                     held_in   = held_ff + 1'b1;
                     total_in  = total_ff + OCT_W'(add_cost);
                  end
               end
               REQ_RESIZE: begin
                  limit_in = lim_ff;
               end
               default: begin
               end
            endcase
            state_in = ST_DONE;
         end

         ST_LOOK_WAIT: begin
            found_in = mem_rd_data;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            done_valid = 1'b1;
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result fields
   assign done_result.status        = status_ff;
   assign done_result.found         = found_ff;
   assign done_result.evicted_count = CNT_OUT_W'(evicted_ff);
   assign done_result.entry_count   = CNT_OUT_W'(held_ff);
   assign done_result.octet_total   = total_ff;

endmodule

// ----- rtl/core/header_dynamic_table_manager.sv -----
`timescale 1ns / 1ps
// header_dynamic_table_manager: size-accounted ring of header entries with lookup
//
//   channel   handshake              payload
//   request   req_valid / req_stall  type, name and value length, entry tag, index, limit
//   response  rsp_valid / rsp_stall  status, found entry, evicted, entries, octet total
//
// One request at a time. A refused add, a lookup miss or a no-op goes straight to the
// response; a lookup hit first reads its entry from the ring memory; an add or an evicting
// size update first evicts the oldest entries, each one read from the ring memory to learn
// its cost, and then commits.
// Synchronous active-high reset empties the table and sets the limit to 4096.
// A waiting response lets the next request in; a later response waits for the register.
module header_dynamic_table_manager
   import hdtm_pkg::*;
#(
   parameter int RING_DEPTH     = DEF_RING_DEPTH,
   parameter int ENTRY_OVERHEAD = DEF_ENTRY_OVERHEAD,
   parameter int STATIC_ENTRIES = DEF_STATIC_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic [LEN_W-1:0]     req_name_len,
   input  logic [LEN_W-1:0]     req_value_len,
   input  logic [TAG_W-1:0]     req_entry_tag,
   input  logic [IDX_W-1:0]     req_lookup_index,
   input  logic [OCT_W-1:0]     req_new_limit,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [TAG_W-1:0]     rsp_found_tag,
   output logic [LEN_W-1:0]     rsp_found_name_len,
   output logic [LEN_W-1:0]     rsp_found_value_len,
   output logic [CNT_OUT_W-1:0] rsp_evicted_count,
   output logic [CNT_OUT_W-1:0] rsp_entry_count,
   output logic [OCT_W-1:0]     rsp_octet_total
);

   localparam int SLOT_W = $clog2(RING_DEPTH);

   logic              done_valid;
   logic              done_take;
   result_type        done_result;
   logic              mem_rd_en;
   logic [SLOT_W-1:0] mem_rd_addr;
   entry_type         mem_rd_data;
   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   hdtm_ctrl #(
      .RING_DEPTH     (RING_DEPTH),
      .ENTRY_OVERHEAD (ENTRY_OVERHEAD),
      .STATIC_ENTRIES (STATIC_ENTRIES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_name_len     (req_name_len),
      .req_value_len    (req_value_len),
      .req_entry_tag    (req_entry_tag),
      .req_lookup_index (req_lookup_index),
      .req_new_limit    (req_new_limit),
      .done_valid       (done_valid),
      .done_take        (done_take),
      .done_result      (done_result),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data)
   );

   hdtm_ring_mem #(
      .DEPTH (RING_DEPTH)
   ) u_ring_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // output register loads when empty or being drained
   assign done_take = done_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_found_tag       = rsp_ff.found.tag;
   assign rsp_found_name_len  = rsp_ff.found.name_len;
   assign rsp_found_value_len = rsp_ff.found.value_len;
   assign rsp_evicted_count   = rsp_ff.evicted_count;
   assign rsp_entry_count     = rsp_ff.entry_count;
   assign rsp_octet_total     = rsp_ff.octet_total;

   // an accepted request blocks the next one in the following cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in progress");

   // a cleared table holds nothing
   a_cleared_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_CLEARED) |->
         (rsp_entry_count == '0 && rsp_octet_total == '0))
      else $error("oversized add left entries in the table");

   // a refused add and a lookup miss evict nothing and return no entry
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_MISSING)) |->
         (rsp_evicted_count == '0 && rsp_found_tag == '0))
      else $error("refused or missing request reported eviction or entry");

   // a new response never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("pending response overwritten");

endmodule

// ----- tb/header_dynamic_table_manager_checker.sv -----
`timescale 1ns / 1ps
// header_dynamic_table_manager_checker: table predictor and response scoreboard
module header_dynamic_table_manager_checker
   import hdtm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic [LEN_W-1:0]     req_name_len,
   input  logic [LEN_W-1:0]     req_value_len,
   input  logic [TAG_W-1:0]     req_entry_tag,
   input  logic [IDX_W-1:0]     req_lookup_index,
   input  logic [OCT_W-1:0]     req_new_limit,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_status,
   input  logic [TAG_W-1:0]     rsp_found_tag,
   input  logic [LEN_W-1:0]     rsp_found_name_len,
   input  logic [LEN_W-1:0]     rsp_found_value_len,
   input  logic [CNT_OUT_W-1:0] rsp_evicted_count,
   input  logic [CNT_OUT_W-1:0] rsp_entry_count,
   input  logic [OCT_W-1:0]     rsp_octet_total,
   output int                   fail_count,
   output int                   pending_count,
   output int                   stored_count,
   output int                   hit_count,
   output int                   full_count,
   output int                   cleared_count,
   output int                   evicted_total,
   output int                   deepest_table
);

   localparam int RING_SLOTS    = DEF_RING_DEPTH;
   localparam int STATIC_COUNT  = DEF_STATIC_ENTRIES;
   localparam int COST_OVERHEAD = DEF_ENTRY_OVERHEAD;

   // shadow copy of the table
   logic [TAG_W-1:0] ring_tag       [RING_SLOTS];
   logic [LEN_W-1:0] ring_name_len  [RING_SLOTS];
   logic [LEN_W-1:0] ring_value_len [RING_SLOTS];
   int               ring_head;
   int               ring_count;
   logic [OCT_W-1:0] octets_used;
   logic [OCT_W-1:0] octets_limit;

   // responses predicted but not yet seen, oldest first
   result_type awaited_responses [$];

   // drop oldest entries until the accounted size is within target
   function automatic int evict_down_to(input logic [OCT_W-1:0] target);
      int               gone;
      int               tail_slot;
      logic [OCT_W-1:0] cost;
      gone = 0;
      while (octets_used > target && ring_count > 0) begin
         tail_slot = (ring_head + ring_count - 1) % RING_SLOTS;
         cost = OCT_W'(ring_name_len[tail_slot]) + OCT_W'(ring_value_len[tail_slot])
                + OCT_W'(COST_OVERHEAD);
         ring_count--;
         octets_used = (octets_used >= cost) ? octets_used - cost : '0;
         gone++;
      end
      if (ring_count == 0)
         octets_used = '0;
      return gone;
   endfunction

   // apply one request to the shadow table and build its response
   function automatic result_type predict_response(
      input logic [1:0]       code,
      input logic [LEN_W-1:0] nlen,
      input logic [LEN_W-1:0] vlen,
      input logic [TAG_W-1:0] tag,
      input logic [IDX_W-1:0] idx,
      input logic [OCT_W-1:0] lim
   );
      result_type       rsp;
      logic [OCT_W-1:0] cost;
      int               evicted;
      int               dyn;
      int               slot;
      rsp     = '0;
      rsp.status = STATUS_OK;
      evicted = 0;
      case (req_code_type'(code))
         REQ_ADD: begin
            cost = OCT_W'(nlen) + OCT_W'(vlen) + OCT_W'(COST_OVERHEAD);
            if (ring_count >= RING_SLOTS) begin
               rsp.status = STATUS_FULL;
            end else if (cost > octets_limit) begin
               evicted    = evict_down_to('0);
               rsp.status = STATUS_CLEARED;
            end else begin
               evicted   = evict_down_to(octets_limit - cost);
               ring_head = (ring_head + RING_SLOTS - 1) % RING_SLOTS;
               ring_tag[ring_head]       = tag;
               ring_name_len[ring_head]  = nlen;
               ring_value_len[ring_head] = vlen;
               ring_count++;
               octets_used = octets_used + cost;
            end
         end
         REQ_LOOKUP: begin
            // static range and anything past the newest-to-oldest run is a miss
            if (int'(idx) <= STATIC_COUNT) begin
               rsp.status = STATUS_MISSING;
            end else begin
               dyn = int'(idx) - STATIC_COUNT - 1;
               if (dyn >= ring_count) begin
                  rsp.status = STATUS_MISSING;
               end else begin
                  slot = (ring_head + dyn) % RING_SLOTS;
                  rsp.found.tag       = ring_tag[slot];
                  rsp.found.name_len  = ring_name_len[slot];
                  rsp.found.value_len = ring_value_len[slot];
               end
            end
         end
         REQ_RESIZE: begin
            if (lim < octets_used)
               evicted = evict_down_to(lim);
            octets_limit = lim;
         end
         default: ;
      endcase
      rsp.evicted_count = CNT_OUT_W'(evicted);
      rsp.entry_count   = CNT_OUT_W'(ring_count);
      rsp.octet_total   = octets_used;
      return rsp;
   endfunction

   function automatic void check_field(input string field,
                                       input logic [31:0] want_value,
                                       input logic [31:0] got_value);
      if (got_value !== want_value) begin
         $error("%s: expected %0d, got %0d", field, want_value, got_value);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         ring_head     = 0;
         ring_count    = 0;
         octets_used   = '0;
         octets_limit  = LIMIT_RESET;
         fail_count    = 0;
         stored_count  = 0;
         hit_count     = 0;
         full_count    = 0;
         cleared_count = 0;
         evicted_total = 0;
         deepest_table = 0;
         for (int i = 0; i < RING_SLOTS; i++) begin
            ring_tag[i]       = '0;
            ring_name_len[i]  = '0;
            ring_value_len[i] = '0;
         end
         awaited_responses.delete();
      end else begin
         // response side first: a response never belongs to a request taken this edge
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response with no request outstanding (status %0d)", rsp_status);
               fail_count++;
            end else begin
               want = awaited_responses.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("found_tag", want.found.tag, rsp_found_tag);
               check_field("found_name_len", 32'(want.found.name_len),
                           32'(rsp_found_name_len));
               check_field("found_value_len", 32'(want.found.value_len),
                           32'(rsp_found_value_len));
               check_field("evicted_count", 32'(want.evicted_count),
                           32'(rsp_evicted_count));
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
               check_field("octet_total", want.octet_total, rsp_octet_total);
            end
         end

         // predict the accepted request
         if (req_valid && !req_stall) begin
            want = predict_response(req_type, req_name_len, req_value_len,
                                    req_entry_tag, req_lookup_index, req_new_limit);
            awaited_responses.push_back(want);
            if (req_type == REQ_ADD && want.status == STATUS_OK)
               stored_count++;
            if (req_type == REQ_LOOKUP && want.status == STATUS_OK)
               hit_count++;
            if (want.status == STATUS_FULL)
               full_count++;
            if (want.status == STATUS_CLEARED)
               cleared_count++;
            evicted_total += int'(want.evicted_count);
            if (int'(want.entry_count) > deepest_table)
               deepest_table = int'(want.entry_count);
         end
      end
      pending_count = awaited_responses.size();
   end

endmodule

// ----- tb/header_dynamic_table_manager_tb.sv -----
`timescale 1ns / 1ps
// header_dynamic_table_manager_tb: request stimulus, response stalls and verdict
module header_dynamic_table_manager_tb;
   import hdtm_pkg::*;

   localparam int RING_SLOTS      = DEF_RING_DEPTH;
   localparam int STATIC_COUNT    = DEF_STATIC_ENTRIES;
   localparam int RESET_CYCLES    = 7;
   localparam int ITEM_TARGET     = 1350;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT  = 20000;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_type = REQ_NOP;
   logic [LEN_W-1:0]     req_name_len = '0;
   logic [LEN_W-1:0]     req_value_len = '0;
   logic [TAG_W-1:0]     req_entry_tag = '0;
   logic [IDX_W-1:0]     req_lookup_index = '0;
   logic [OCT_W-1:0]     req_new_limit = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [TAG_W-1:0]     rsp_found_tag;
   logic [LEN_W-1:0]     rsp_found_name_len;
   logic [LEN_W-1:0]     rsp_found_value_len;
   logic [CNT_OUT_W-1:0] rsp_evicted_count;
   logic [CNT_OUT_W-1:0] rsp_entry_count;
   logic [OCT_W-1:0]     rsp_octet_total;

   int fail_count;
   int pending_count;
   int stored_count;
   int hit_count;
   int full_count;
   int cleared_count;
   int evicted_total;
   int deepest_table;

   int requests_sent = 0;
   bit calm = 1'b0;
   bit hold_off_req = 1'b0;
   bit hold_off_seen = 1'b0;

   header_dynamic_table_manager uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_name_len        (req_name_len),
      .req_value_len       (req_value_len),
      .req_entry_tag       (req_entry_tag),
      .req_lookup_index    (req_lookup_index),
      .req_new_limit       (req_new_limit),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_found_tag       (rsp_found_tag),
      .rsp_found_name_len  (rsp_found_name_len),
      .rsp_found_value_len (rsp_found_value_len),
      .rsp_evicted_count   (rsp_evicted_count),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_octet_total     (rsp_octet_total)
   );

   header_dynamic_table_manager_checker table_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_name_len        (req_name_len),
      .req_value_len       (req_value_len),
      .req_entry_tag       (req_entry_tag),
      .req_lookup_index    (req_lookup_index),
      .req_new_limit       (req_new_limit),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_found_tag       (rsp_found_tag),
      .rsp_found_name_len  (rsp_found_name_len),
      .rsp_found_value_len (rsp_found_value_len),
      .rsp_evicted_count   (rsp_evicted_count),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_octet_total     (rsp_octet_total),
      .fail_count          (fail_count),
      .pending_count       (pending_count),
      .stored_count        (stored_count),
      .hit_count           (hit_count),
      .full_count          (full_count),
      .cleared_count       (cleared_count),
      .evicted_total       (evicted_total),
      .deepest_table       (deepest_table)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle stretch length: mostly short, a few long
   function automatic int idle_stretch();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(1, 3);
      if (pick < 95)
         return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   // lengths: mostly small entries, some mid-size, a few across the full range
   function automatic logic [LEN_W-1:0] random_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         return LEN_W'($urandom_range(0, 120));
      if (pick < 95)
         return LEN_W'($urandom_range(0, 1500));
      return LEN_W'($urandom_range(0, 65535));
   endfunction

   // offer one request, with an optional gap first, and wait until it is taken
   task automatic offer_request(input req_code_type code,
                                input logic [LEN_W-1:0] nlen,
                                input logic [LEN_W-1:0] vlen,
                                input logic [TAG_W-1:0] tag,
                                input logic [IDX_W-1:0] idx,
                                input logic [OCT_W-1:0] lim);
      int gap;
      gap = (calm || $urandom_range(0, 99) < 50) ? 0 : idle_stretch();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= code;
      req_name_len     <= nlen;
      req_value_len    <= vlen;
      req_entry_tag    <= tag;
      req_lookup_index <= idx;
      req_new_limit    <= lim;
      do @(posedge clock); while (req_stall !== 1'b0);
      requests_sent++;
   endtask

   // unused payload fields carry random values
   task automatic insert_entry(input logic [LEN_W-1:0] nlen, input logic [LEN_W-1:0] vlen,
                               input logic [TAG_W-1:0] tag);
      offer_request(REQ_ADD, nlen, vlen, tag, IDX_W'($urandom), $urandom);
   endtask

   task automatic look_up(input logic [IDX_W-1:0] idx);
      offer_request(REQ_LOOKUP, LEN_W'($urandom), LEN_W'($urandom), $urandom, idx,
                    $urandom);
   endtask

   task automatic resize_table(input logic [OCT_W-1:0] lim);
      offer_request(REQ_RESIZE, LEN_W'($urandom), LEN_W'($urandom), $urandom,
                    IDX_W'($urandom), lim);
   endtask

   task automatic offer_nop();
      offer_request(REQ_NOP, LEN_W'($urandom), LEN_W'($urandom), $urandom,
                    IDX_W'($urandom), $urandom);
   endtask

   // one random request; lookups mostly land within span entries of the newest
   task automatic random_request(input int span);
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      if (pick < 45) begin
         insert_entry(random_length(), random_length(), $urandom);
      end else if (pick < 82) begin
         if (sel < 70)
            look_up(IDX_W'(STATIC_COUNT + 1 + $urandom_range(0, span)));
         else if (sel < 85)
            look_up(IDX_W'($urandom_range(0, STATIC_COUNT)));
         else
            look_up(IDX_W'($urandom));
      end else if (pick < 92) begin
         if (sel < 40)
            resize_table($urandom_range(0, 8192));
         else if (sel < 75)
            resize_table(LIMIT_RESET);
         else if (sel < 85)
            resize_table($urandom_range(0, 300));
         else if (sel < 95)
            resize_table($urandom);
         else
            resize_table('0);
      end else begin
         offer_nop();
      end
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_off_seen) begin
            hold_off_seen = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 30) begin
            rsp_stall <= 1'b1;
            repeat (idle_stretch()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: too long with nothing moving on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus and verdict
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // static range, empty table and top index all miss
      look_up('0);
      look_up(IDX_W'(STATIC_COUNT));
      look_up(IDX_W'(STATIC_COUNT + 1));
      look_up('1);
      // smallest and tagged entries, then hits and a miss just past them
      insert_entry('0, '0, '0);
      insert_entry(16'd100, 16'd200, '1);
      look_up(IDX_W'(STATIC_COUNT + 1));
      look_up(IDX_W'(STATIC_COUNT + 2));
      look_up(IDX_W'(STATIC_COUNT + 3));
      // oversized entry clears the table
      insert_entry('1, '1, 32'hA5A5_A5A5);
      offer_nop();
      // largest limit, so the largest entry fits
      resize_table('1);
      insert_entry('1, '1, 32'h5A5A_5A5A);
      look_up(IDX_W'(STATIC_COUNT + 1));
      insert_entry(16'd10, 16'd20, $urandom);
      // shrinking evicts, down to an empty table
      resize_table(32'd100);
      look_up(IDX_W'(STATIC_COUNT + 1));
      resize_table('0);
      insert_entry('0, '0, $urandom);
      // exact fit, then an add that must evict to fit
      resize_table(32'd32);
      insert_entry('0, '0, $urandom);
      insert_entry('0, '0, $urandom);
      resize_table(LIMIT_RESET);
      look_up(IDX_W'(STATIC_COUNT + 1));
      offer_nop();

      // random mix with gaps on both sides
      repeat (250) random_request(40);

      // fill the ring past its depth, probe deep indexes, then shrink back
      resize_table(32'h0100_0000);
      repeat (RING_SLOTS + 6)
         insert_entry(LEN_W'($urandom_range(0, 24)), LEN_W'($urandom_range(0, 24)),
                      $urandom);
      look_up(IDX_W'(STATIC_COUNT + RING_SLOTS));
      look_up(IDX_W'(STATIC_COUNT + RING_SLOTS + 1));
      repeat (12) look_up(IDX_W'(STATIC_COUNT + 1 + $urandom_range(0, RING_SLOTS - 1)));
      resize_table($urandom_range(2000, 6000));

      // back-to-back stretch with no idling
      calm = 1'b1;
      repeat (200) random_request(40);
      calm = 1'b0;

      // long response hold-off while requests keep coming
      hold_off_req = 1'b1;
      repeat (150) random_request(40);

      while (requests_sent < ITEM_TARGET)
         random_request(60);
      req_valid <= 1'b0;

      // drain
      calm = 1'b1;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests: %0d entries stored, %0d lookup hits,",
               requests_sent, stored_count, hit_count);
      $display("%0d full-ring refusals, %0d oversized clears, %0d evicted, peak %0d entries",
               full_count, cleared_count, evicted_total, deepest_table);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
